// ===== rtl/rgbthumb_pkg.sv =====
// Shared constants, lookup tables and register indexes for the RGB565 gray
// thumbnail downscaler. No dependencies.
`default_nettype none

package rgbthumb_pkg;

  // Default thumbnail edge and source dimension clamp
  localparam int THUMB_SIZE_DEF  = 32;
  localparam int MAX_SRC_DIM_DEF = 1024;

  // Fixed field widths
  localparam int SRC_DIM_W = 10;
  localparam int PIXEL_W   = 16;
  localparam int GRAY_W    = 8;
  localparam int THUMB_W   = 5;
  localparam int CFG_IDX_W = 1;

  // Configuration register reset values
  localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 10'd176;
  localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 10'd144;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

  // Q16 luma weights (sum is 65536)
  localparam int LUMA_SUM_W = 24;
  localparam logic [LUMA_SUM_W-1:0] W_RED   = 24'd19595;
  localparam logic [LUMA_SUM_W-1:0] W_GREEN = 24'd38470;
  localparam logic [LUMA_SUM_W-1:0] W_BLUE  = 24'd7471;

  typedef logic [GRAY_W-1:0] lut32_t [32];
  typedef logic [GRAY_W-1:0] lut64_t [64];

  // c*255/max with truncation, built at elaboration
  function automatic lut32_t build_exp5();
    lut32_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = GRAY_W'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic lut64_t build_exp6();
    lut64_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = GRAY_W'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam lut32_t EXP5_LUT = build_exp5();
  localparam lut64_t EXP6_LUT = build_exp6();

endpackage

`default_nettype wire

// ===== rtl/rgbthumb_gray.sv =====
// RGB565 to 8-bit luminance, purely combinational.
// Uses rgbthumb_pkg for the channel expansion tables and luma weights.
`default_nettype none

module rgbthumb_gray
  import rgbthumb_pkg::*;
(
  input  wire logic [PIXEL_W-1:0] pixel,
  output logic      [GRAY_W-1:0]  gray
);

  logic [GRAY_W-1:0]     red8;
  logic [GRAY_W-1:0]     green8;
  logic [GRAY_W-1:0]     blue8;
  logic [LUMA_SUM_W-1:0] luma_sum;

  assign red8   = EXP5_LUT[pixel[15:11]];
  assign green8 = EXP6_LUT[pixel[10:5]];
  assign blue8  = EXP5_LUT[pixel[4:0]];

  // weights sum to 1.0 in Q16, so the sum never exceeds 24 bits
  assign luma_sum = W_RED   * LUMA_SUM_W'(red8)
                  + W_GREEN * LUMA_SUM_W'(green8)
                  + W_BLUE  * LUMA_SUM_W'(blue8);

  assign gray = luma_sum[LUMA_SUM_W-1 -: GRAY_W];

endmodule

`default_nettype wire

// ===== rtl/rgb565_gray_thumbnail_downscaler_top.sv =====
// RGB565 gray thumbnail downscaler: top level with counters and pick logic.
// Pipeline: input reg, then result reg; a picked item stalls while the result is held.
// Throughput: one pixel item per cycle unless a picked item stalls; others never do.
// Reset (rst_n, synchronous): pipeline empty, counters zero, sizes 176x144,
// block waits for a pixel item flagged frame_start before emitting anything.
// Depends on rgbthumb_pkg and rgbthumb_gray.
`default_nettype none

module rgb565_gray_thumbnail_downscaler_top
  import rgbthumb_pkg::*;
#(
  parameter int THUMB_SIZE  = THUMB_SIZE_DEF,
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SRC_DIM_W-1:0] cfg_wdata,

  // pixel item input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIXEL_W-1:0]   in_pixel_rgb565,
  input  wire logic                 in_frame_start,

  // thumbnail item output
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [GRAY_W-1:0]    out_gray_value,
  output logic      [THUMB_W-1:0]   out_thumb_col,
  output logic      [THUMB_W-1:0]   out_thumb_row,
  output logic                      out_thumb_last
);

  localparam int CW = $clog2(THUMB_SIZE);   // thumbnail counter width
  localparam int PW = CW + SRC_DIM_W;       // pick product width

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SRC_DIM_W-1:0] src_width_r;
  logic [SRC_DIM_W-1:0] src_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective dimensions: clamped to [THUMB_SIZE, MAX_SRC_DIM]
  logic [SRC_DIM_W-1:0] eff_width;
  logic [SRC_DIM_W-1:0] eff_height;

  always_comb begin
    eff_width = src_width_r;
    if (int'(src_width_r) < THUMB_SIZE)  eff_width = SRC_DIM_W'(THUMB_SIZE);
    if (int'(eff_width) > MAX_SRC_DIM)   eff_width = SRC_DIM_W'(MAX_SRC_DIM);
    eff_height = src_height_r;
    if (int'(src_height_r) < THUMB_SIZE) eff_height = SRC_DIM_W'(THUMB_SIZE);
    if (int'(eff_height) > MAX_SRC_DIM)  eff_height = SRC_DIM_W'(MAX_SRC_DIM);
  end

  // ---------------------------------------------------------------------------
  // Input register: one pixel item waiting to be processed
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               s1_start_r;
  logic               s1_fire;     // s1 item processed this cycle
  logic               s1_emit;     // s1 item yields a thumbnail item

  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pixel_r <= in_pixel_rgb565;
      s1_start_r <= in_frame_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [SRC_DIM_W-1:0] src_col_r,  src_col_nxt;
  logic [SRC_DIM_W-1:0] src_row_r,  src_row_nxt;
  logic [CW-1:0]        out_col_r,  out_col_nxt;
  logic [CW-1:0]        out_row_r,  out_row_nxt;
  logic [SRC_DIM_W-1:0] pick_col_r, pick_col_nxt;
  logic [SRC_DIM_W-1:0] pick_row_r, pick_row_nxt;
  logic                 done_r,     done_nxt;

  // values after an optional frame-start clear
  logic [SRC_DIM_W-1:0] cur_src_col, cur_src_row;
  logic [CW-1:0]        cur_out_col, cur_out_row;
  logic [SRC_DIM_W-1:0] cur_pick_col, cur_pick_row;
  logic                 cur_done;

  logic [CW:0]          out_col_inc, out_row_inc;
  logic [CW-1:0]        adv_out_col, adv_out_row;
  logic                 is_last;
  logic [PW-1:0]        pick_col_prod, pick_row_prod;
  logic [SRC_DIM_W:0]   src_col_inc;

  always_comb begin
    if (s1_start_r) begin
      cur_src_col  = '0;
      cur_src_row  = '0;
      cur_out_col  = '0;
      cur_out_row  = '0;
      cur_pick_col = '0;
      cur_pick_row = '0;
      cur_done     = 1'b0;
    end else begin
      cur_src_col  = src_col_r;
      cur_src_row  = src_row_r;
      cur_out_col  = out_col_r;
      cur_out_row  = out_row_r;
      cur_pick_col = pick_col_r;
      cur_pick_row = pick_row_r;
      cur_done     = done_r;
    end
  end

  assign s1_emit = s1_valid_r && !cur_done &&
                   (cur_src_row == cur_pick_row) && (cur_src_col == cur_pick_col);

  // a non-picked item drains regardless of the output side
  assign s1_fire = s1_valid_r && (!s1_emit || !out_valid || out_ready);

  // thumbnail position advance, raster order
  always_comb begin
    out_col_inc = (CW+1)'(cur_out_col) + (CW+1)'(1);
    out_row_inc = (CW+1)'(cur_out_row) + (CW+1)'(1);
    is_last     = 1'b0;
    adv_out_col = out_col_inc[CW-1:0];
    adv_out_row = cur_out_row;
    if (out_col_inc >= (CW+1)'(THUMB_SIZE)) begin
      adv_out_col = '0;
      adv_out_row = out_row_inc[CW-1:0];
      if (out_row_inc >= (CW+1)'(THUMB_SIZE)) begin
        adv_out_row = '0;
        is_last     = 1'b1;
      end
    end
  end

  // next source position to pick: floor(pos * dim / THUMB_SIZE)
  assign pick_col_prod = PW'(adv_out_col) * PW'(eff_width);
  assign pick_row_prod = PW'(adv_out_row) * PW'(eff_height);

  assign src_col_inc = (SRC_DIM_W+1)'(cur_src_col) + (SRC_DIM_W+1)'(1);

  always_comb begin
    src_col_nxt  = cur_src_col;
    src_row_nxt  = cur_src_row;
    out_col_nxt  = cur_out_col;
    out_row_nxt  = cur_out_row;
    pick_col_nxt = cur_pick_col;
    pick_row_nxt = cur_pick_row;
    done_nxt     = cur_done;
    if (!cur_done) begin
      if (s1_emit) begin
        out_col_nxt = adv_out_col;
        out_row_nxt = adv_out_row;
        if (is_last) begin
          done_nxt     = 1'b1;
          pick_col_nxt = '0;
          pick_row_nxt = '0;
        end else begin
          pick_col_nxt = SRC_DIM_W'(pick_col_prod / PW'(THUMB_SIZE));
          pick_row_nxt = SRC_DIM_W'(pick_row_prod / PW'(THUMB_SIZE));
        end
      end
      // wrap as soon as the column reaches or passes the width
      if (src_col_inc >= (SRC_DIM_W+1)'(eff_width)) begin
        src_col_nxt = '0;
        src_row_nxt = cur_src_row + SRC_DIM_W'(1);
      end else begin
        src_col_nxt = src_col_inc[SRC_DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pick_col_r <= '0;
      pick_row_r <= '0;
      done_r     <= 1'b1;
    end else if (s1_fire) begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      pick_col_r <= pick_col_nxt;
      pick_row_r <= pick_row_nxt;
      done_r     <= done_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Luminance and result register
  // ---------------------------------------------------------------------------
  logic [GRAY_W-1:0] gray;

  rgbthumb_gray u_gray (
    .pixel (s1_pixel_r),
    .gray  (gray)
  );

  logic               out_valid_r;
  logic [GRAY_W-1:0]  out_gray_r;
  logic [THUMB_W-1:0] out_col_fld_r;
  logic [THUMB_W-1:0] out_row_fld_r;
  logic               out_last_r;
  logic               out_load;

  assign out_load = s1_fire && s1_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_gray_r    <= gray;
      out_col_fld_r <= THUMB_W'(cur_out_col);
      out_row_fld_r <= THUMB_W'(cur_out_row);
      out_last_r    <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gray_value = out_gray_r;
  assign out_thumb_col  = out_col_fld_r;
  assign out_thumb_row  = out_row_fld_r;
  assign out_thumb_last = out_last_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_rgb565_gray_thumbnail_downscaler_top.sv =====
// Self-checking testbench for rgb565_gray_thumbnail_downscaler_top: random pixel
// streams against a built-in predictor of the gray conversion and the 32x32 picks.
// Depends on rgbthumb_pkg and the downscaler RTL.
`default_nettype none

module tb_rgb565_gray_thumbnail_downscaler_top;
  import rgbthumb_pkg::*;

  localparam int          THUMB_EDGE  = THUMB_SIZE_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PIPE_TAIL   = 6;      // covers the input and result registers
  // Q16 luma weights
  localparam int unsigned LUMA_R      = 19595;
  localparam int unsigned LUMA_G      = 38470;
  localparam int unsigned LUMA_B      = 7471;

  // one input item waiting to be sent; drain holds it back until all results are in
  typedef struct packed {
    logic [PIXEL_W-1:0] rgb;
    logic               sof;
    logic               drain;
  } pixel_item_t;

  // one expected thumbnail pixel
  typedef struct packed {
    logic [GRAY_W-1:0]  gray;
    logic [THUMB_W-1:0] col;
    logic [THUMB_W-1:0] row;
    logic               last;
  } thumb_px_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_SRC_WIDTH;
  logic [SRC_DIM_W-1:0] cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [PIXEL_W-1:0]   in_pixel_rgb565 = '0;
  logic                 in_frame_start  = 1'b0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [GRAY_W-1:0]    out_gray_value;
  logic [THUMB_W-1:0]   out_thumb_col;
  logic [THUMB_W-1:0]   out_thumb_row;
  logic                 out_thumb_last;

  rgb565_gray_thumbnail_downscaler_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_rgb565 (in_pixel_rgb565),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_gray_value  (out_gray_value),
    .out_thumb_col   (out_thumb_col),
    .out_thumb_row   (out_thumb_row),
    .out_thumb_last  (out_thumb_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the size registers and of the frame
  // counters, advanced once per accepted pixel item.
  // ---------------------------------------------------------------------------
  logic [SRC_DIM_W-1:0] size_w     = SRC_WIDTH_RST;
  logic [SRC_DIM_W-1:0] size_h     = SRC_HEIGHT_RST;
  int unsigned          col_pos    = 0;
  int unsigned          row_pos    = 0;
  int unsigned          thumb_x    = 0;
  int unsigned          thumb_y    = 0;
  int unsigned          pick_col   = 0;
  int unsigned          pick_row   = 0;
  bit                   frame_idle = 1'b1;   // nothing is emitted before a frame start

  pixel_item_t          pixel_q[$];          // items still to be sent
  thumb_px_t            thumb_q[$];          // thumbnail pixels still owed by the block

  pixel_item_t          cur_px      = '0;
  bit                   presenting  = 1'b0;
  int                   gap_left    = 0;
  int                   burst_left  = 0;

  int                   cycle_count   = 0;
  int                   mismatches    = 0;
  int                   px_accepted   = 0;
  int                   thumbs_seen   = 0;
  int                   frames_closed = 0;
  int                   stall_mode    = 0;

  // sizes below the thumbnail edge behave as the edge itself
  function automatic int unsigned eff_size(logic [SRC_DIM_W-1:0] reg_val);
    return (reg_val < THUMB_EDGE) ? THUMB_EDGE : int'(reg_val);
  endfunction

  function automatic logic [GRAY_W-1:0] rgb565_luma(logic [PIXEL_W-1:0] px);
    int unsigned r8, g8, b8;
    r8 = int'(px[15:11]) * 255 / 31;
    g8 = int'(px[10:5]) * 255 / 63;
    b8 = int'(px[4:0]) * 255 / 31;
    return GRAY_W'((LUMA_R * r8 + LUMA_G * g8 + LUMA_B * b8) >> 16);
  endfunction

  // Advance the frame position by one source pixel and queue the thumbnail
  // pixel it yields, if it lands on the next pick.
  function automatic void track_pixel(logic [PIXEL_W-1:0] px, logic sof);
    thumb_px_t t;
    if (sof) begin
      col_pos    = 0;
      row_pos    = 0;
      thumb_x    = 0;
      thumb_y    = 0;
      pick_col   = 0;
      pick_row   = 0;
      frame_idle = 1'b0;
    end
    if (frame_idle) return;

    if (row_pos == pick_row && col_pos == pick_col) begin
      t.gray = rgb565_luma(px);
      t.col  = thumb_x[THUMB_W-1:0];
      t.row  = thumb_y[THUMB_W-1:0];
      t.last = 1'b0;
      thumb_x++;
      if (thumb_x >= THUMB_EDGE) begin
        thumb_x = 0;
        thumb_y++;
        if (thumb_y >= THUMB_EDGE) begin
          thumb_y = 0;
          t.last  = 1'b1;
        end
      end
      thumb_q.push_back(t);
      if (t.last) begin
        frame_idle = 1'b1;
        pick_col   = 0;
        pick_row   = 0;
      end else begin
        pick_col = thumb_x * eff_size(size_w) / THUMB_EDGE;
        pick_row = thumb_y * eff_size(size_h) / THUMB_EDGE;
      end
    end

    // column wraps on reaching or passing the current width
    col_pos++;
    if (col_pos >= eff_size(size_w)) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'h3FF;
    end
    col_pos &= 32'h3FF;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending items and sends them in bursts with random gaps.
  // Valid stays up with a fixed payload until the item is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_pixel_rgb565 <= '0;
      in_frame_start  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_pixel(cur_px.rgb, cur_px.sof);
        presenting = 1'b0;
        px_accepted++;
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() > 0 && !(pixel_q[0].drain && thumb_q.size() > 0)) begin
          cur_px     = pixel_q.pop_front();
          presenting = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a third of the bursts run straight into the next one
            burst_left = $urandom_range(0, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid        <= presenting;
      in_pixel_rgb565 <= cur_px.rgb;
      in_frame_start  <= cur_px.sof;
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: result-side ready follows a randomly re-chosen stall pattern; each taken
  // result is checked against the oldest expectation.
  // Also owns the cycle limit.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    thumb_px_t t;
    logic      next_ready;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d thumbnail pixels still owed", $time, thumb_q.size());
      $display("rgb565_gray_thumbnail_downscaler_top test failed");
      $finish;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (thumb_q.size() == 0) begin
          $display("%0t: unexpected thumbnail pixel gray %0d col %0d row %0d last %0d",
                   $time, out_gray_value, out_thumb_col, out_thumb_row, out_thumb_last);
          mismatches++;
        end else begin
          t = thumb_q.pop_front();
          check_field("gray_value", t.gray, out_gray_value);
          check_field("thumb_col", t.col, out_thumb_col);
          check_field("thumb_row", t.row, out_thumb_row);
          check_field("thumb_last", t.last, out_thumb_last);
          if (t.last) frames_closed++;
        end
        thumbs_seen++;
      end
      if (cycle_count % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       next_ready = 1'b1;                            // no backpressure
        1:       next_ready = ($urandom_range(0, 3) != 0);     // light random stalls
        2:       next_ready = (cycle_count % 5 != 2);          // periodic one-cycle stall
        default: next_ready = ((cycle_count & 8) == 0);        // alternating stall and ready windows
      endcase
      out_ready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return PIXEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_one(input logic [PIXEL_W-1:0] rgb, input logic sof);
    pixel_q.push_back('{rgb: rgb, sof: sof, drain: 1'b0});
  endtask

  // restart_pm: per-mille chance of a stray frame start inside the run;
  // drain_at: index of the item that waits for all results first (-1: none)
  task automatic add_pixels(input int count, input bit first_sof, input int restart_pm,
                            input int drain_at);
    pixel_item_t it;
    for (int i = 0; i < count; i++) begin
      it.rgb   = rand_pixel();
      it.sof   = (i == 0) ? first_sof : ($urandom_range(0, 999) < restart_pm);
      it.drain = (i == drain_at);
      pixel_q.push_back(it);
    end
  endtask

  // everything sent, every result back, pipeline flushed
  task automatic settle();
    while (pixel_q.size() != 0 || presenting || thumb_q.size() != 0) @(posedge clk);
    repeat (PIPE_TAIL) @(posedge clk);
  endtask

  // only called while the block is idle, so the predictor copy switches at once
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                            input logic [SRC_DIM_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_SRC_WIDTH) size_w = value;
    else                      size_h = value;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset size 176x144.
    // Pixels before any frame start are dropped.
    add_one(16'hFFFF, 1'b0);
    add_one(16'h0000, 1'b0);
    add_one(16'h1234, 1'b0);
    // Each frame start pixel is source (0,0) and always emitted: walk the
    // color extremes through it, restarting mid-frame every time.
    add_one(16'hFFFF, 1'b1);
    add_one(16'h0000, 1'b1);
    add_one(16'hF800, 1'b1);
    add_one(16'h07E0, 1'b1);
    add_one(16'h001F, 1'b1);
    add_one(16'h0821, 1'b1);
    add_one(16'h8410, 1'b1);
    add_one(16'h7BEF, 1'b1);
    // at width 176 the next pick is source column 5
    add_one(16'hFFFF, 1'b0);
    add_one(16'h0000, 1'b0);
    add_one(16'hAAAA, 1'b0);
    add_one(16'h5555, 1'b0);
    add_one(16'hFFFF, 1'b0);
    add_one(16'h0001, 1'b0);
    settle();

    // Width zero clamps to the thumbnail edge: every pixel of the first rows is
    // a pick. The sender halts midway until every result is back.
    write_size(REG_SRC_WIDTH, 10'd0);
    write_size(REG_SRC_HEIGHT, 10'd32);
    add_pixels(120, 1'b1, 0, 60);
    settle();

    // Largest frame: sparse picks along row 0 only.
    write_size(REG_SRC_WIDTH, 10'd1023);
    write_size(REG_SRC_HEIGHT, 10'd1023);
    add_pixels(60, 1'b1, 0, -1);
    settle();

    // Sizes changed in the middle of a frame; the stream carries on without
    // a new frame start and may skip a pick.
    write_size(REG_SRC_WIDTH, 10'd40);
    write_size(REG_SRC_HEIGHT, 10'd33);
    add_pixels(100, 1'b1, 0, -1);
    settle();
    write_size(REG_SRC_WIDTH, 10'd64);
    write_size(REG_SRC_HEIGHT, 10'd100);
    add_pixels(80, 1'b0, 0, -1);
    settle();

    // 33 wide, height below the edge: every column but the last is a pick in each
    // source row; the sender halts midway once more.
    write_size(REG_SRC_WIDTH, 10'd33);
    write_size(REG_SRC_HEIGHT, 10'd31);
    add_pixels(100, 1'b1, 0, 50);
    settle();

    // Mid-size frames with occasional stray frame starts.
    write_size(REG_SRC_WIDTH, 10'd100);
    write_size(REG_SRC_HEIGHT, 10'd50);
    add_pixels(130, 1'b1, 10, -1);
    settle();
    repeat (PIPE_TAIL) @(posedge clk);

    $display("Sent %0d pixel items over sizes from clamped 32 up to 1023, checked %0d",
             px_accepted, thumbs_seen);
    $display("thumbnail pixels and %0d complete thumbnails; %0d mismatches.",
             frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("rgb565_gray_thumbnail_downscaler_top test passed");
    end else begin
      $display("rgb565_gray_thumbnail_downscaler_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rgb565_gray_thumbnail_downscaler_top.f =====
rtl/rgbthumb_pkg.sv
rtl/rgbthumb_gray.sv
rtl/rgb565_gray_thumbnail_downscaler_top.sv
tb/sv/tb_rgb565_gray_thumbnail_downscaler_top.sv
